// ----- src/oamd_pkg.sv -----
// Shared types and constants for the opcode ALU with serial multiply and divide.
// Used by oamd_step_unit and opcode_alu_serial_mul_div; depends on nothing.
package oamd_pkg;

	localparam int CMD_W          = 8;
	localparam int RESULT_W       = 32;
	localparam int ACC_W          = RESULT_W + 1;
	localparam int DEF_OPERAND_W  = 32;
	localparam int S_TDATA_W      = CMD_W + 2 * RESULT_W;

	// Raw opcode bytes
	localparam logic [CMD_W-1:0] OP_ADD = 8'h01;
	localparam logic [CMD_W-1:0] OP_SUB = 8'h02;
	localparam logic [CMD_W-1:0] OP_MUL = 8'h04;
	localparam logic [CMD_W-1:0] OP_DIV = 8'h08;
	localparam logic [CMD_W-1:0] OP_OR  = 8'h10;
	localparam logic [CMD_W-1:0] OP_XOR = 8'h20;

	typedef enum logic [2:0] {
		K_ADD,
		K_SUB,
		K_MUL,
		K_DIV,
		K_OR,
		K_XOR,
		K_BAD
	} op_kind_t;

	typedef struct packed {
		op_kind_t              kind;
		logic [ACC_W-1:0]      acc;     // running product or partial remainder
		logic [RESULT_W-1:0]   opa;
		logic [RESULT_W-1:0]   opb;     // addend, shifted multiplicand or divisor
		logic                  abit;    // operand A bit consumed this step
		logic                  bzero;
		logic                  sticky;  // a one bit of the dividend was already seen
	} step_in_t;

	typedef struct packed {
		logic [ACC_W-1:0]      acc_next;
		logic                  qbit;
		logic [RESULT_W-1:0]   res;
	} step_out_t;

endpackage

// ----- src/oamd_step_unit.sv -----
// One step of the ALU: add, subtract, one multiply accumulate or one restoring
// divide trial around a single shared adder, or a bitwise OR or XOR. Depends on oamd_pkg.
module oamd_step_unit (
	input  oamd_pkg::step_in_t  step_in,
	output oamd_pkg::step_out_t step_out
);
	import oamd_pkg::*;

	logic [ACC_W-1:0] add_x;
	logic [ACC_W-1:0] add_y;
	logic             add_cin;
	logic [ACC_W:0]   add_sum;
	logic [ACC_W-1:0] rem_shift;

	assign rem_shift = {step_in.acc[ACC_W-2:0], step_in.abit};
	assign add_sum   = {1'b0, add_x} + {1'b0, add_y} + (ACC_W + 1)'(add_cin);

	always_comb begin
		add_x   = ACC_W'(step_in.opa);
		add_y   = ACC_W'(step_in.opb);
		add_cin = 1'b0;
		unique case (step_in.kind)
			K_SUB: begin
				add_y   = ~ACC_W'(step_in.opb);
				add_cin = 1'b1;
			end
			K_MUL: begin
				add_x = {1'b0, step_in.acc[RESULT_W-1:0]};
				add_y = step_in.abit ? ACC_W'(step_in.opb) : '0;
			end
			K_DIV: begin
				add_x   = rem_shift;
				add_y   = ~ACC_W'(step_in.opb);
				add_cin = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		step_out.acc_next = step_in.acc;
		step_out.qbit     = 1'b0;
		step_out.res      = '0;
		unique case (step_in.kind)
			K_ADD, K_SUB: step_out.res = add_sum[RESULT_W-1:0];
			K_MUL: step_out.acc_next = {1'b0, add_sum[RESULT_W-1:0]};
			K_DIV: begin
				// carry out set means no borrow: the divisor fits
				if (step_in.bzero) begin
					step_out.qbit = step_in.sticky | step_in.abit;
				end else begin
					step_out.qbit = add_sum[ACC_W];
				end
				step_out.acc_next = add_sum[ACC_W] ? add_sum[ACC_W-1:0] : rem_shift;
			end
			K_OR:  step_out.res = step_in.opa | step_in.opb;
			K_XOR: step_out.res = step_in.opa ^ step_in.opb;
			default: step_out.res = '0;
		endcase
	end

endmodule

// ----- src/opcode_alu_serial_mul_div.sv -----
// Top level of the opcode ALU: stream ports, sequencer and operand registers.
// Depends on oamd_pkg and oamd_step_unit.
//
// Takes one word {operand_b, operand_a, cmd} and returns one 32-bit result
// with a bad-opcode flag in tuser. Add, subtract, OR and XOR take a single step
// in the shared step unit; multiply (shift-and-add, LSB first) and restoring
// divide (MSB first) take OPERAND_WIDTH steps, one operand bit per cycle
// through the same adder. Input ready is low from accept until the result
// word is taken. Operands use only their low OPERAND_WIDTH bits. Divide by
// zero returns a run of ones one longer than the dividend's bit length,
// capped at 32 bits. An unknown opcode byte, including one with several
// code bits set, returns zero with tuser set.
module opcode_alu_serial_mul_div #(
	parameter int OPERAND_WIDTH = oamd_pkg::DEF_OPERAND_W
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [7:0] cmd, [39:8] operand_a, [71:40] operand_b
	input  logic [oamd_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [31:0] result_value
	output logic [oamd_pkg::RESULT_W-1:0]      m_axis_tdata,
	// [0] bad_opcode
	output logic                               m_axis_tuser
);
	import oamd_pkg::*;

	localparam int W     = OPERAND_WIDTH;
	localparam int CNT_W = $clog2(W);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t             state_q;
	op_kind_t           kind_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ACC_W-1:0]   acc_q;
	logic [W-1:0]       opa_q;
	logic [RESULT_W-1:0] opb_q;
	logic [W-1:0]       quo_q;
	logic               bzero_q;
	logic               sticky_q;
	logic [RESULT_W-1:0] res_q;
	logic               bad_q;

	logic [CMD_W-1:0]    in_cmd;
	logic [W-1:0]        in_a;
	logic [W-1:0]        in_b;
	op_kind_t            in_kind;
	logic                in_accept;
	logic                out_accept;
	step_in_t            step_in;
	step_out_t           step_out;
	logic [W-1:0]        quo_next;
	logic [RESULT_W:0]   dz_word;
	logic                last_step;

	assign in_cmd = s_axis_tdata[CMD_W-1:0];
	assign in_a   = s_axis_tdata[CMD_W +: W];
	assign in_b   = s_axis_tdata[CMD_W + RESULT_W +: W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_DONE);
	assign m_axis_tdata  = res_q;
	assign m_axis_tuser  = bad_q;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_accept    = m_axis_tvalid && m_axis_tready;

	always_comb begin
		unique case (in_cmd)
			OP_ADD:  in_kind = K_ADD;
			OP_SUB:  in_kind = K_SUB;
			OP_MUL:  in_kind = K_MUL;
			OP_DIV:  in_kind = K_DIV;
			OP_OR:   in_kind = K_OR;
			OP_XOR:  in_kind = K_XOR;
			default: in_kind = K_BAD;
		endcase
	end

	always_comb begin
		step_in.kind   = kind_q;
		step_in.acc    = acc_q;
		step_in.opa    = RESULT_W'(opa_q);
		step_in.opb    = opb_q;
		step_in.abit   = (kind_q == K_MUL) ? opa_q[0] : opa_q[W-1];
		step_in.bzero  = bzero_q;
		step_in.sticky = sticky_q;
	end

	oamd_step_unit u_step (
		.step_in  (step_in),
		.step_out (step_out)
	);

	assign quo_next  = {quo_q[W-2:0], step_out.qbit};
	// divide by zero: one more one above the dividend's bit length
	assign dz_word   = {(RESULT_W)'(quo_next), 1'b1};
	assign last_step = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_accept) state_q <= ST_EXEC;
				ST_EXEC: begin
					if (!(kind_q == K_MUL || kind_q == K_DIV) || last_step) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: if (out_accept) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_q   <= in_kind;
			cnt_q    <= CNT_W'(W - 1);
			acc_q    <= '0;
			opa_q    <= in_a;
			opb_q    <= RESULT_W'(in_b);
			quo_q    <= '0;
			bzero_q  <= (in_b == '0);
			sticky_q <= 1'b0;
			bad_q    <= (in_kind == K_BAD);
		end else if (state_q == ST_EXEC) begin
			acc_q <= step_out.acc_next;
			quo_q <= quo_next;
			cnt_q <= cnt_q - CNT_W'(1);
			if (kind_q == K_MUL) begin
				// advance: consume multiplier LSB, double the multiplicand
				opa_q <= opa_q >> 1;
				opb_q <= opb_q << 1;
			end else begin
				opa_q    <= opa_q << 1;
				sticky_q <= sticky_q | opa_q[W-1];
			end
			priority if (kind_q == K_MUL) begin
				if (last_step) res_q <= step_out.acc_next[RESULT_W-1:0];
			end else if (kind_q == K_DIV) begin
				if (last_step) begin
					res_q <= bzero_q ? dz_word[RESULT_W-1:0] : RESULT_W'(quo_next);
				end
			end else begin
				res_q <= step_out.res;
			end
		end
	end

	// single-item sequencer: never takes input while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while result pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !m_axis_tvalid && !s_axis_tready)
		else $error("result or ready right after accept");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("bad opcode with nonzero result");

endmodule

// ----- dv/tb_opcode_alu_serial_mul_div.sv -----
// Testbench for opcode_alu_serial_mul_div: directed and random opcode words with random gaps
// and stalls, each result checked against a predictor kept in this file.
// Depends on oamd_pkg and the RTL under src/.
module tb_opcode_alu_serial_mul_div;
	timeunit 1ns;
	timeprecision 1ps;

	import oamd_pkg::*;

	localparam int OPND_W      = DEF_OPERAND_W;
	localparam int RANDOM_WORDS = 500;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 2 * (OPND_W + 2);

	typedef struct packed {
		logic [RESULT_W-1:0] b;
		logic [RESULT_W-1:0] a;
		logic [CMD_W-1:0]    cmd;
	} alu_word_t;

	typedef struct packed {
		logic                bad;
		logic [RESULT_W-1:0] value;
	} alu_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [RESULT_W-1:0] m_axis_tdata;
	logic m_axis_tuser;

	alu_word_t   pending_words[$];
	alu_result_t expected_results[$];
	int          mismatch_count = 0;
	int          idle_cycles = 0;
	bit          word_taken = 1'b0;
	int          src_gap = 0;
	int          sink_wait = 0;
	int          calm_left = 0;

	opcode_alu_serial_mul_div #(.OPERAND_WIDTH(OPND_W)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic alu_result_t predict_result(alu_word_t w);
		logic [RESULT_W-1:0] mask;
		logic [RESULT_W-1:0] a;
		logic [RESULT_W-1:0] b;
		logic [RESULT_W-1:0] mcand;
		logic [RESULT_W:0]   rem;
		int                  len;
		alu_result_t         r;
		mask = (OPND_W >= RESULT_W) ? '1 : ((RESULT_W'(1) << OPND_W) - 1);
		a = w.a & mask;
		b = w.b & mask;
		r = '0;
		case (w.cmd)
			OP_ADD: r.value = a + b;
			OP_SUB: r.value = a - b;
			OP_MUL: begin
				mcand = b;
				for (int i = 0; i < RESULT_W; i++) begin
					if (a[i])
						r.value = r.value + mcand;
					mcand = mcand << 1;
				end
			end
			OP_DIV: begin
				if (b == '0) begin
					// run of ones one longer than the dividend's bit length
					len = 0;
					while (len < RESULT_W && (a >> len) != '0)
						len++;
					r.value = (len + 1 >= RESULT_W) ? '1 : ((RESULT_W'(1) << (len + 1)) - 1);
				end else begin
					rem = '0;
					for (int i = RESULT_W - 1; i >= 0; i--) begin
						rem = {rem[RESULT_W-1:0], a[i]};
						r.value = r.value << 1;
						if (rem >= {1'b0, b}) begin
							rem = rem - {1'b0, b};
							r.value[0] = 1'b1;
						end
					end
				end
			end
			OP_OR:  r.value = a | b;
			OP_XOR: r.value = a ^ b;
			default: r.bad = 1'b1;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [RESULT_W-1:0] got,
			logic [RESULT_W-1:0] want);
		$display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic push_word(logic [CMD_W-1:0] cmd, logic [RESULT_W-1:0] a,
			logic [RESULT_W-1:0] b);
		alu_word_t w;
		w.cmd = cmd;
		w.a   = a;
		w.b   = b;
		pending_words.push_back(w);
	endtask

	function automatic logic [RESULT_W-1:0] rand_operand();
		case ($urandom_range(0, 6))
			0: return $urandom_range(0, 255);
			1: return $urandom_range(0, 1) ? '1 : '0;
			2: return RESULT_W'(1) << $urandom_range(0, RESULT_W - 1);
			3: return '1 - $urandom_range(0, 15);
			4: return $urandom() >> $urandom_range(0, RESULT_W - 1);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [CMD_W-1:0] rand_cmd();
		logic [CMD_W-1:0] ops[6];
		ops = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_OR, OP_XOR};
		if ($urandom_range(0, 9) == 0)
			return CMD_W'($urandom_range(0, 255));
		return ops[$urandom_range(0, 5)];
	endfunction

	// source: hold a word until taken, then wait the drawn gap before the next
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (s_axis_tvalid && !word_taken) begin
			s_axis_tvalid <= 1'b1;
		end else begin
			word_taken = 1'b0;
			if (src_gap > 0) begin
				src_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				s_axis_tdata  <= pending_words.pop_front();
				s_axis_tvalid <= 1'b1;
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(0, 19) == 0)
					calm_left = $urandom_range(10, 30);
				src_gap = (calm_left > 0) ? 0 : $urandom_range(0, 4);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// sink: stall a drawn number of cycles once a result word shows up
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (m_axis_tvalid && sink_wait > 0) begin
			sink_wait--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(predict_result(alu_word_t'(s_axis_tdata)));
				word_taken = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				alu_result_t want;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result_value", m_axis_tdata, '0);
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tdata !== want.value)
						report_mismatch("result_value", m_axis_tdata, want.value);
					if (m_axis_tuser !== want.bad)
						report_mismatch("bad_opcode", RESULT_W'(m_axis_tuser),
							RESULT_W'(want.bad));
				end
				sink_wait = (calm_left > 0) ? 0 : $urandom_range(0, 4);
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		logic [CMD_W-1:0] cmd;
		// extremes, every opcode, divide by zero and unknown bytes
		push_word(OP_ADD, '1, '1);
		push_word(OP_ADD, '0, '0);
		push_word(OP_SUB, '0, 32'd1);
		push_word(OP_SUB, '1, '1);
		push_word(OP_MUL, '1, '1);
		push_word(OP_MUL, '0, 32'h1234_5678);
		push_word(OP_MUL, 32'h0001_0000, 32'h0001_0000);
		push_word(OP_DIV, '1, 32'd1);
		push_word(OP_DIV, 32'd7, 32'd2);
		push_word(OP_DIV, 32'd5, '1);
		push_word(OP_DIV, '1, 32'h8000_0000);
		push_word(OP_DIV, '0, '0);
		push_word(OP_DIV, 32'd1, '0);
		push_word(OP_DIV, 32'h4000_0000, '0);
		push_word(OP_DIV, 32'h8000_0000, '0);
		push_word(OP_OR, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
		push_word(OP_XOR, '1, 32'h0F0F_0F0F);
		push_word(OP_XOR, '0, '0);
		push_word(8'h00, '1, '1);
		push_word(8'hFF, 32'd3, 32'd4);
		push_word(OP_ADD | OP_SUB, 32'd3, 32'd4);
		push_word(8'h40, 32'd9, 32'd9);
		push_word(8'h80, 32'd9, 32'd9);
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			cmd = rand_cmd();
			// favor small divisors so quotients are not mostly zero
			if (cmd == OP_DIV && $urandom_range(0, 2) == 0)
				push_word(cmd, rand_operand(), $urandom_range(0, 15));
			else
				push_word(cmd, rand_operand(), rand_operand());
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending_words.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/oamd_pkg.sv
src/oamd_step_unit.sv
src/opcode_alu_serial_mul_div.sv
dv/tb_opcode_alu_serial_mul_div.sv
